>>> hdl/button_dimmer_channels_top_assert.svh
// Assertion macros shared by the dimmer channel bank.
`ifndef BUTTON_DIMMER_CHANNELS_TOP_ASSERT_SVH
`define BUTTON_DIMMER_CHANNELS_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, switched off while reset is asserted.
`define BDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that a condition never holds.
`define BDC_ASSERT_NEVER(label, cond, msg) \
	`BDC_ASSERT(label, !(cond), msg)

`else

`define BDC_ASSERT(label, prop, msg)
`define BDC_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> hdl/bdc_pkg.sv
// Types and codes shared by the dimmer channel bank.
`timescale 1ns / 1ps

package bdc_pkg;

	// Item function codes.
	localparam logic [1:0] FUNC_PROC  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Value selectors for write and read items.
	localparam logic [3:0] VID_PRESS = 4'd0;
	localparam logic [3:0] VID_MODE  = 4'd1;
	localparam logic [3:0] VID_LEVEL = 4'd2;

	// Channel modes.
	localparam logic [2:0] MODE_OFF  = 3'd0;
	localparam logic [2:0] MODE_ON   = 3'd1;
	localparam logic [2:0] MODE_AUTO = 3'd2;
	localparam logic [2:0] MODE_UP   = 3'd3;
	localparam logic [2:0] MODE_DOWN = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_LONG_PRESS = 3'd0;
	localparam logic [2:0] CFG_STEP_PRESS = 3'd1;
	localparam logic [2:0] CFG_LEVEL_MIN  = 3'd2;
	localparam logic [2:0] CFG_LEVEL_MAX  = 3'd3;
	localparam logic [2:0] CFG_LEVEL_STEP = 3'd4;
	localparam logic [2:0] CFG_HOLD       = 3'd5;
	localparam logic [2:0] CFG_RAMP       = 3'd6;

	// Press word layout.
	localparam int PRESS_BIT = 15;

	typedef struct packed {
		logic [14:0] long_press_ms;
		logic [14:0] step_press_ms;
		logic [15:0] level_min;
		logic [15:0] level_max;
		logic [15:0] level_step;
		logic [15:0] hold_timeout_ms;
		logic [15:0] ramp_period_ms;
	} cfg_t;

	typedef struct packed {
		logic [15:0] press_word;
		logic [2:0]  mode;
		logic [15:0] level;
		logic [31:0] press_time;
	} chan_state_t;

endpackage

>>> hdl/bdc_cfg.sv
// Configuration register file of the dimmer channel bank.
`timescale 1ns / 1ps

module bdc_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output bdc_pkg::cfg_t cfg
);

	bdc_pkg::cfg_t cfg_q;

	// Writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms   <= 15'd500;
			cfg_q.step_press_ms   <= 15'd50;
			cfg_q.level_min       <= 16'd10;
			cfg_q.level_max       <= 16'd255;
			cfg_q.level_step      <= 16'd10;
			cfg_q.hold_timeout_ms <= 16'd1000;
			cfg_q.ramp_period_ms  <= 16'd50;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bdc_pkg::CFG_LONG_PRESS: cfg_q.long_press_ms   <= cfg_data[14:0];
				bdc_pkg::CFG_STEP_PRESS: cfg_q.step_press_ms   <= cfg_data[14:0];
				bdc_pkg::CFG_LEVEL_MIN:  cfg_q.level_min       <= cfg_data;
				bdc_pkg::CFG_LEVEL_MAX:  cfg_q.level_max       <= cfg_data;
				bdc_pkg::CFG_LEVEL_STEP: cfg_q.level_step      <= cfg_data;
				bdc_pkg::CFG_HOLD:       cfg_q.hold_timeout_ms <= cfg_data;
				bdc_pkg::CFG_RAMP:       cfg_q.ramp_period_ms  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hdl/bdc_store.sv
// Per-channel state store: one read port and one write port.
`timescale 1ns / 1ps

module bdc_store #(
	parameter int CHANNELS = 16,
	parameter int IDX_W    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     rd_idx,
	output bdc_pkg::chan_state_t rd_state,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  bdc_pkg::chan_state_t wr_state
);

	bdc_pkg::chan_state_t state_q [CHANNELS];

	// The read is combinational so that an update lands before the next word.
	assign rd_state = state_q[rd_idx];

	// All channels clear to off, level zero, no pending press.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else if (wr_en) begin
			state_q[wr_idx] <= wr_state;
		end
	end

endmodule

>>> hdl/bdc_step.sv
// Next-state and result logic for one channel and one word.
`timescale 1ns / 1ps

module bdc_step (
	input  bdc_pkg::cfg_t        cfg,
	input  bdc_pkg::chan_state_t cur,
	input  logic                 in_range,
	input  logic [1:0]           func,
	input  logic [3:0]           value_id,
	input  logic [15:0]          value,
	input  logic [31:0]          now_ms,
	output bdc_pkg::chan_state_t nxt,
	output logic                 wr_en,
	output logic [15:0]          read_data,
	output logic [15:0]          level_out,
	output logic                 level_changed
);

	logic [14:0] dur;
	logic        is_long;
	logic        step_ok;
	logic [31:0] elapsed;
	logic [15:0] sum_up;
	logic [16:0] down_floor;
	logic        below_floor;
	logic [15:0] auto_level;
	logic [15:0] rd;
	logic        we;

	// Shared compares and adds.
	assign dur         = cur.press_word[14:0];
	assign is_long     = dur >= cfg.long_press_ms;
	assign step_ok     = dur >= cfg.step_press_ms;
	assign elapsed     = now_ms - cur.press_time;
	assign sum_up      = cur.level + cfg.level_step;
	assign down_floor  = {1'b0, cfg.level_min} + {1'b0, cfg.level_step};
	assign below_floor = {1'b0, cur.level} < down_floor;

	// Function decode and channel update.
	always_comb begin
		nxt        = cur;
		rd         = '0;
		we         = 1'b0;
		auto_level = cur.level;
		unique case (func)
			bdc_pkg::FUNC_PROC: begin
				we = 1'b1;
				if (cur.press_word[bdc_pkg::PRESS_BIT]) begin
					// A pending press acts on mode and level, then is consumed.
					nxt.press_time = now_ms;
					nxt.press_word = '0;
					unique case (cur.mode) inside
						bdc_pkg::MODE_OFF: begin
							if (is_long) begin
								nxt.level = cfg.level_min;
								nxt.mode  = bdc_pkg::MODE_UP;
							end else begin
								nxt.level = '0;
								nxt.mode  = bdc_pkg::MODE_AUTO;
							end
						end
						bdc_pkg::MODE_ON, bdc_pkg::MODE_AUTO: begin
							if (is_long) begin
								nxt.mode = bdc_pkg::MODE_DOWN;
							end else begin
								nxt.level = '0;
								nxt.mode  = bdc_pkg::MODE_OFF;
							end
						end
						bdc_pkg::MODE_UP: begin
							if (step_ok) begin
								nxt.level = (sum_up > cfg.level_max) ? cfg.level_min : sum_up;
							end
						end
						bdc_pkg::MODE_DOWN: begin
							if (step_ok) begin
								nxt.level = below_floor ? cfg.level_max
									: cur.level - cfg.level_step;
							end
						end
						default: begin
						end
					endcase
				end else if (cur.mode == bdc_pkg::MODE_UP || cur.mode == bdc_pkg::MODE_DOWN) begin
					// Manual ramping falls back to on after the hold time.
					if (elapsed > {16'd0, cfg.hold_timeout_ms}) begin
						nxt.mode       = bdc_pkg::MODE_ON;
						nxt.press_time = '0;
					end
				end else if (cur.mode == bdc_pkg::MODE_AUTO) begin
					// Automatic ramp counts up once per period and stops at the top.
					if (elapsed > {16'd0, cfg.ramp_period_ms}) begin
						auto_level     = cur.level + 16'd1;
						nxt.press_time = now_ms;
					end
					nxt.level = auto_level;
					if (auto_level == cfg.level_max) begin
						nxt.mode       = bdc_pkg::MODE_ON;
						nxt.press_time = '0;
					end
				end
			end
			bdc_pkg::FUNC_WRITE: begin
				unique case (value_id)
					bdc_pkg::VID_PRESS: begin
						we             = 1'b1;
						nxt.press_word = value;
					end
					bdc_pkg::VID_MODE: begin
						we       = 1'b1;
						nxt.mode = (value > 16'd4) ? bdc_pkg::MODE_OFF : value[2:0];
					end
					bdc_pkg::VID_LEVEL: begin
						we        = 1'b1;
						nxt.level = value;
					end
					default: begin
					end
				endcase
			end
			bdc_pkg::FUNC_READ: begin
				unique case (value_id)
					bdc_pkg::VID_PRESS: rd = cur.press_word;
					bdc_pkg::VID_MODE:  rd = {13'd0, cur.mode};
					bdc_pkg::VID_LEVEL: rd = cur.level;
					default:            rd = '0;
				endcase
			end
			default: begin
			end
		endcase
	end

	// A channel past the bank touches nothing and reports zeros.
	assign wr_en         = we && in_range;
	assign read_data     = in_range ? rd : 16'd0;
	assign level_out     = in_range ? nxt.level : 16'd0;
	assign level_changed = in_range && (func == bdc_pkg::FUNC_PROC) && (nxt.level != cur.level);

endmodule

>>> hdl/button_dimmer_channels_top.sv
// Top level of the button-driven dimmer channel bank.
`timescale 1ns / 1ps

// A bank of CHANNELS dimmer channels whose state sits in flip-flops. Each word
// on the request channel is taken into an input register, and once the output
// register is free one read-modify-write of the addressed channel produces the
// result word in the output register and updates the store at the same edge, so
// a word can be accepted every cycle while the output is not stalled, including
// back to back on one channel. The single channel-store access per cycle sets this rate.
// The output register holds a result while rsp_stall is high, and the input
// register keeps one more word until it frees up. Configuration writes are taken
// in any cycle (cfg_ready is tied high) and must only be made while the bank idles.
module button_dimmer_channels_top #(
	parameter int CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  channel,
	input  logic [3:0]  value_id,
	input  logic [15:0] value,
	input  logic [31:0] now_ms,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [3:0]  channel_out,
	output logic [15:0] read_data,
	output logic [15:0] level_out,
	output logic        level_changed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	bdc_pkg::cfg_t        cfg;
	bdc_pkg::chan_state_t cur_state;
	bdc_pkg::chan_state_t nxt_state;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [3:0]  channel_s1;
	logic [3:0]  value_id_s1;
	logic [15:0] value_s1;
	logic [31:0] now_s1;

	logic        rsp_valid_q;
	logic [3:0]  channel_out_q;
	logic [15:0] read_data_q;
	logic [15:0] level_out_q;
	logic        level_changed_q;

	logic        advance;
	logic        accept;
	logic        in_range;
	logic        step_we;
	logic        store_we;
	logic [15:0] step_rd;
	logic [15:0] step_level;
	logic        step_changed;

	// Handshake: the input register moves on whenever the output register frees.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign in_range  = {1'b0, channel_s1} < 5'(CHANNELS);
	assign store_we  = valid_s1 && advance && step_we;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func;
			channel_s1  <= channel;
			value_id_s1 <= value_id;
			value_s1    <= value;
			now_s1      <= now_ms;
		end
	end

	bdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdc_store #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (channel_s1[IDX_W-1:0]),
		.rd_state (cur_state),
		.wr_en    (store_we),
		.wr_idx   (channel_s1[IDX_W-1:0]),
		.wr_state (nxt_state)
	);

	bdc_step u_step (
		.cfg           (cfg),
		.cur           (cur_state),
		.in_range      (in_range),
		.func          (func_s1),
		.value_id      (value_id_s1),
		.value         (value_s1),
		.now_ms        (now_s1),
		.nxt           (nxt_state),
		.wr_en         (step_we),
		.read_data     (step_rd),
		.level_out     (step_level),
		.level_changed (step_changed)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			channel_out_q   <= channel_s1;
			read_data_q     <= step_rd;
			level_out_q     <= step_level;
			level_changed_q <= step_changed;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign channel_out   = channel_out_q;
	assign read_data     = read_data_q;
	assign level_out     = level_out_q;
	assign level_changed = level_changed_q;

`include "button_dimmer_channels_top_assert.svh"

	// The request side only stalls when the input register is holding a word.
	`BDC_ASSERT(a_stall_needs_word, req_stall |-> valid_s1, "stall without a held word")
	// A held word reaches the output register once that register frees.
	`BDC_ASSERT(a_word_moves, (valid_s1 && advance) |=> rsp_valid, "held word was lost")
	// Only process words report a level change, and they never return read data.
	`BDC_ASSERT(a_change_no_read, (rsp_valid && level_changed) |-> (read_data == 16'd0),
		"level change reported with read data")
	// A channel past the bank reports zeros.
	`BDC_ASSERT_NEVER(a_out_of_range,
		rsp_valid && ({1'b0, channel_out} >= 5'(CHANNELS)) && (level_out != 16'd0 || level_changed),
		"channel past the bank reported a level")

endmodule

>>> test/button_dimmer_channels_top_tb.sv
// Self-checking testbench for the button-driven dimmer channel bank.
`timescale 1ns / 1ps

module button_dimmer_channels_top_tb;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 10;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int NUM_CHANNELS = 16;

	// Function code that the bank leaves unused.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	// Register settings applied between phases.
	localparam int PROFILE_DEFAULT = 0;
	localparam int PROFILE_SMALL = 1;
	localparam int PROFILE_FULL = 2;
	localparam int PROFILE_ZERO = 3;
	localparam int PROFILE_RANDOM = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [1:0] func;
	logic [3:0] channel;
	logic [3:0] value_id;
	logic [15:0] value;
	logic [31:0] now_ms;
	logic rsp_valid;
	logic rsp_stall;
	logic [3:0] channel_out;
	logic [15:0] read_data;
	logic [15:0] level_out;
	logic level_changed;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	// One result word as the bank should report it.
	typedef struct packed {
		logic [3:0] chan;
		logic [15:0] rd;
		logic [15:0] lvl;
		logic chg;
	} level_report_t;

	// Mirror of the channel store and registers, and the queue of awaited results.
	class dimmer_scoreboard;
		logic [14:0] long_ms;
		logic [14:0] step_ms;
		logic [15:0] lvl_min;
		logic [15:0] lvl_max;
		logic [15:0] lvl_step;
		logic [15:0] hold_ms;
		logic [15:0] ramp_ms;
		logic [15:0] press_q[NUM_CHANNELS];
		logic [2:0] mode_q[NUM_CHANNELS];
		logic [15:0] lvl_q[NUM_CHANNELS];
		logic [31:0] stamp_q[NUM_CHANNELS];
		level_report_t level_reports[$];
		int errors;

		function new();
			long_ms = 15'd500;
			step_ms = 15'd50;
			lvl_min = 16'd10;
			lvl_max = 16'd255;
			lvl_step = 16'd10;
			hold_ms = 16'd1000;
			ramp_ms = 16'd50;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				press_q[i] = '0;
				mode_q[i] = bdc_pkg::MODE_OFF;
				lvl_q[i] = '0;
				stamp_q[i] = '0;
			end
			errors = 0;
		endfunction

		function void write_register(logic [2:0] idx, logic [15:0] data);
			case (idx)
				bdc_pkg::CFG_LONG_PRESS: long_ms = data[14:0];
				bdc_pkg::CFG_STEP_PRESS: step_ms = data[14:0];
				bdc_pkg::CFG_LEVEL_MIN: lvl_min = data;
				bdc_pkg::CFG_LEVEL_MAX: lvl_max = data;
				bdc_pkg::CFG_LEVEL_STEP: lvl_step = data;
				bdc_pkg::CFG_HOLD: hold_ms = data;
				bdc_pkg::CFG_RAMP: ramp_ms = data;
				default: ;
			endcase
		endfunction

		// Press handling and timeouts of one channel for a process word.
		function void advance_channel(logic [3:0] ch, logic [31:0] now);
			logic [14:0] dur;
			logic [15:0] lv;
			logic [31:0] elapsed;
			bit is_long;
			dur = press_q[ch][14:0];
			lv = lvl_q[ch];
			if (press_q[ch][bdc_pkg::PRESS_BIT]) begin
				is_long = (dur >= long_ms);
				stamp_q[ch] = now;
				case (mode_q[ch])
					bdc_pkg::MODE_OFF: begin
						if (is_long) begin
							lv = lvl_min;
							mode_q[ch] = bdc_pkg::MODE_UP;
						end else begin
							lv = '0;
							mode_q[ch] = bdc_pkg::MODE_AUTO;
						end
					end
					bdc_pkg::MODE_ON, bdc_pkg::MODE_AUTO: begin
						if (is_long) begin
							mode_q[ch] = bdc_pkg::MODE_DOWN;
						end else begin
							lv = '0;
							mode_q[ch] = bdc_pkg::MODE_OFF;
						end
					end
					bdc_pkg::MODE_UP: begin
						if (dur >= step_ms) begin
							lv = lv + lvl_step;
							if (lv > lvl_max)
								lv = lvl_min;
						end
					end
					bdc_pkg::MODE_DOWN: begin
						if (dur >= step_ms) begin
							// The floor compare is done at 17 bits so it cannot wrap.
							if ({1'b0, lv} < ({1'b0, lvl_min} + {1'b0, lvl_step}))
								lv = lvl_max;
							else
								lv = lv - lvl_step;
						end
					end
					default: ;
				endcase
				press_q[ch] = '0;
			end else begin
				elapsed = now - stamp_q[ch];
				if (mode_q[ch] == bdc_pkg::MODE_UP || mode_q[ch] == bdc_pkg::MODE_DOWN) begin
					if (elapsed > {16'd0, hold_ms}) begin
						mode_q[ch] = bdc_pkg::MODE_ON;
						stamp_q[ch] = '0;
					end
				end
				if (mode_q[ch] == bdc_pkg::MODE_AUTO) begin
					if (elapsed > {16'd0, ramp_ms}) begin
						lv = lv + 16'd1;
						stamp_q[ch] = now;
					end
					if (lv == lvl_max) begin
						mode_q[ch] = bdc_pkg::MODE_ON;
						stamp_q[ch] = '0;
					end
				end
			end
			lvl_q[ch] = lv;
		endfunction

		// Apply an accepted request word and queue the result it should give.
		function void note_request(logic [1:0] fn, logic [3:0] ch, logic [3:0] vid,
				logic [15:0] val, logic [31:0] now);
			level_report_t rep;
			logic [15:0] prior;
			prior = lvl_q[ch];
			rep.chan = ch;
			rep.rd = '0;
			rep.chg = 1'b0;
			case (fn)
				bdc_pkg::FUNC_PROC: begin
					advance_channel(ch, now);
					rep.chg = (lvl_q[ch] != prior);
				end
				bdc_pkg::FUNC_WRITE: begin
					if (vid == bdc_pkg::VID_PRESS)
						press_q[ch] = val;
					else if (vid == bdc_pkg::VID_MODE)
						mode_q[ch] = (val > 16'd4) ? bdc_pkg::MODE_OFF : val[2:0];
					else if (vid == bdc_pkg::VID_LEVEL)
						lvl_q[ch] = val;
				end
				bdc_pkg::FUNC_READ: begin
					if (vid == bdc_pkg::VID_PRESS)
						rep.rd = press_q[ch];
					else if (vid == bdc_pkg::VID_MODE)
						rep.rd = {13'd0, mode_q[ch]};
					else if (vid == bdc_pkg::VID_LEVEL)
						rep.rd = lvl_q[ch];
				end
				default: ;
			endcase
			rep.lvl = lvl_q[ch];
			level_reports.push_back(rep);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare an accepted result word with the oldest awaited one.
		function void check_report(logic [3:0] ch, logic [15:0] rd, logic [15:0] lvl,
				logic chg);
			level_report_t want;
			if (level_reports.size() == 0) begin
				$display("%0t: result word for channel %0h with none awaited", $time, ch);
				errors++;
				return;
			end
			want = level_reports.pop_front();
			compare_field("channel_out", {12'd0, want.chan}, {12'd0, ch});
			compare_field("read_data", want.rd, rd);
			compare_field("level_out", want.lvl, lvl);
			compare_field("level_changed", {15'd0, want.chg}, {15'd0, chg});
		endfunction
	endclass

	dimmer_scoreboard board;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;
	logic [31:0] clock_ms;

	button_dimmer_channels_top #(
		.CHANNELS(NUM_CHANNELS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.channel(channel),
		.value_id(value_id),
		.value(value),
		.now_ms(now_ms),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.channel_out(channel_out),
		.read_data(read_data),
		.level_out(level_out),
		.level_changed(level_changed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Receiver back-pressure.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Watch both channels and the register port, and guard against a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				board.note_request(func, channel, value_id, value, now_ms);
			if (rsp_valid && !rsp_stall)
				board.check_report(channel_out, read_data, level_out, level_changed);
			if (cfg_valid && cfg_ready)
				board.write_register(cfg_index, cfg_data);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("button_dimmer_channels_top_tb: done, errors");
				$finish;
			end
		end
	end

	// Offer one request word and hold it until the bank takes it.
	task automatic send_item(logic [1:0] fn, logic [3:0] ch, logic [3:0] vid,
			logic [15:0] val, logic [31:0] now);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func <= fn;
		channel <= ch;
		value_id <= vid;
		value <= val;
		now_ms <= now;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Stop sending and wait until every awaited result word has come back.
	task automatic drain;
		req_valid <= 1'b0;
		// Let the monitor note the last accepted word before the queue is read.
		@(posedge clk);
		while (board.level_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all registers, including the unused index, with one setting.
	task automatic apply_profile(int kind);
		logic [15:0] vals[8];
		for (int i = 0; i < 8; i++) begin
			case (kind)
				PROFILE_FULL: vals[i] = 16'hffff;
				PROFILE_ZERO: vals[i] = 16'h0000;
				default: vals[i] = 16'($urandom());
			endcase
		end
		if (kind == PROFILE_DEFAULT) begin
			vals[bdc_pkg::CFG_LONG_PRESS] = 16'd500;
			vals[bdc_pkg::CFG_STEP_PRESS] = 16'd50;
			vals[bdc_pkg::CFG_LEVEL_MIN] = 16'd10;
			vals[bdc_pkg::CFG_LEVEL_MAX] = 16'd255;
			vals[bdc_pkg::CFG_LEVEL_STEP] = 16'd10;
			vals[bdc_pkg::CFG_HOLD] = 16'd1000;
			vals[bdc_pkg::CFG_RAMP] = 16'd50;
		end else if (kind == PROFILE_SMALL) begin
			// Small thresholds so that ramps wrap and timeouts fire often.
			vals[bdc_pkg::CFG_LONG_PRESS] = 16'($urandom_range(30, 400));
			vals[bdc_pkg::CFG_STEP_PRESS] = 16'($urandom_range(5, 60));
			vals[bdc_pkg::CFG_LEVEL_MIN] = 16'($urandom_range(0, 20));
			vals[bdc_pkg::CFG_LEVEL_MAX] = vals[bdc_pkg::CFG_LEVEL_MIN] +
				16'($urandom_range(5, 60));
			vals[bdc_pkg::CFG_LEVEL_STEP] = 16'($urandom_range(1, 15));
			vals[bdc_pkg::CFG_HOLD] = 16'($urandom_range(20, 300));
			vals[bdc_pkg::CFG_RAMP] = 16'($urandom_range(0, 20));
		end
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Time step between words: short, near the ramp period, near the hold, or long.
	task automatic step_clock;
		case ($urandom_range(0, 3))
			0: clock_ms = clock_ms + 32'($urandom_range(0, 10));
			1: clock_ms = clock_ms + 32'($urandom_range(0, 2 * board.ramp_ms + 2));
			2: clock_ms = clock_ms + {16'd0, board.hold_ms} + 32'($urandom_range(0, 4)) - 32'd2;
			default: clock_ms = clock_ms + 32'($urandom_range(0, 3000));
		endcase
	endtask

	// Random words, many of them press-then-process sequences, mostly on a few channels.
	task automatic run_random(int count);
		int sent;
		int pick;
		logic [3:0] ch;
		logic [14:0] dur;
		logic [15:0] val;
		sent = 0;
		while (sent < count) begin
			ch = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				case ($urandom_range(0, 3))
					0: dur = 15'($urandom());
					1: dur = board.long_ms + 15'($urandom_range(0, 4)) - 15'd2;
					2: dur = board.step_ms + 15'($urandom_range(0, 4)) - 15'd2;
					default: dur = 15'($urandom_range(0, 100));
				endcase
				val = {($urandom_range(0, 7) != 0), dur};
				send_item(bdc_pkg::FUNC_WRITE, ch, bdc_pkg::VID_PRESS, val, 32'($urandom()));
				step_clock();
				send_item(bdc_pkg::FUNC_PROC, ch, 4'($urandom()), 16'($urandom()), clock_ms);
				sent += 2;
			end else if (pick < 65) begin
				step_clock();
				send_item(bdc_pkg::FUNC_PROC, ch, 4'($urandom()), 16'($urandom()), clock_ms);
				sent++;
			end else if (pick < 72) begin
				val = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom());
				send_item(bdc_pkg::FUNC_WRITE, ch, bdc_pkg::VID_MODE, val, 32'($urandom()));
				sent++;
			end else if (pick < 78) begin
				val = $urandom_range(0, 1) ? board.lvl_max - 16'($urandom_range(0, 3)) :
					16'($urandom());
				send_item(bdc_pkg::FUNC_WRITE, ch, bdc_pkg::VID_LEVEL, val, 32'($urandom()));
				sent++;
			end else if (pick < 90) begin
				val = 16'($urandom());
				send_item(bdc_pkg::FUNC_READ, ch, ($urandom_range(0, 3) == 0) ? 4'($urandom()) :
					4'($urandom_range(0, 2)), val, 32'($urandom()));
				sent++;
			end else begin
				send_item(2'($urandom()), 4'($urandom()), 4'($urandom()), 16'($urandom()),
					32'($urandom()));
				sent++;
			end
		end
	endtask

	// Walk one channel through every mode and the field extremes.
	task automatic run_directed;
		clock_ms = 32'd1000;
		send_item(bdc_pkg::FUNC_READ, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		send_item(bdc_pkg::FUNC_READ, 4'd0, bdc_pkg::VID_MODE, 16'h0000, clock_ms);
		send_item(bdc_pkg::FUNC_READ, 4'd0, 4'hf, 16'hffff, clock_ms);
		// Long press while off starts the manual ramp up.
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000 | 16'd600, clock_ms);
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000 | 16'd50, clock_ms);
		clock_ms += 32'd100;
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		// A press just short of a step leaves the level alone.
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000 | 16'd49, clock_ms);
		clock_ms += 32'd100;
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		// Idle past the hold time returns to on.
		clock_ms += 32'd1001;
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000 | 16'd500, clock_ms);
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		// Step down to the floor, then wrap to the maximum.
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000 | 16'd60, clock_ms);
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000 | 16'd60, clock_ms);
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		clock_ms += 32'd1001;
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		// Short presses: on goes off, off starts the automatic ramp.
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000 | 16'd10, clock_ms);
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_PRESS, 16'h8000, clock_ms);
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_LEVEL, 16'd254, clock_ms);
		clock_ms += 32'd51;
		send_item(bdc_pkg::FUNC_PROC, 4'd0, bdc_pkg::VID_PRESS, 16'h0000, clock_ms);
		// A mode code above four stores off.
		send_item(bdc_pkg::FUNC_WRITE, 4'd0, bdc_pkg::VID_MODE, 16'd7, clock_ms);
		send_item(bdc_pkg::FUNC_READ, 4'd0, bdc_pkg::VID_MODE, 16'h0000, clock_ms);
		// Field extremes, an ignored value id and the unused function code.
		send_item(bdc_pkg::FUNC_WRITE, 4'hf, bdc_pkg::VID_PRESS, 16'hffff, 32'hffff_ffff);
		send_item(bdc_pkg::FUNC_PROC, 4'hf, bdc_pkg::VID_PRESS, 16'h0000, 32'hffff_ffff);
		send_item(bdc_pkg::FUNC_WRITE, 4'hf, 4'd9, 16'hffff, 32'h0000_0000);
		send_item(FUNC_SPARE, 4'hf, 4'hf, 16'hffff, 32'hffff_ffff);
		drain();
	endtask

	// Phase table: register setting, sender idling and receiver stalling.
	initial begin
		int kinds[8];
		int idles[8];
		int stalls[8];
		kinds = '{PROFILE_SMALL, PROFILE_FULL, PROFILE_ZERO, PROFILE_RANDOM,
			PROFILE_SMALL, PROFILE_DEFAULT, PROFILE_RANDOM, PROFILE_SMALL};
		idles = '{0, 84, 0, 30, 0, 30, 84, 0};
		stalls = '{0, 0, 84, 30, 0, 30, 0, 84};
		board = new();
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		func <= bdc_pkg::FUNC_PROC;
		channel <= '0;
		value_id <= bdc_pkg::VID_PRESS;
		value <= '0;
		now_ms <= '0;
		rsp_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= bdc_pkg::CFG_LONG_PRESS;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int p = 0; p < 8; p++) begin
			apply_profile(kinds[p]);
			idle_pct = idles[p];
			stall_pct = stalls[p];
			// One phase starts just below the wrap of the time stamp.
			clock_ms = (p == 4) ? 32'hffff_fc00 : 32'($urandom());
			run_random(ITEMS_PER_PHASE);
			drain();
			idle_pct = 0;
			stall_pct = 0;
		end

		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.level_reports.size() == 0)
			$display("button_dimmer_channels_top_tb: done, clean");
		else
			$display("button_dimmer_channels_top_tb: done, errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/bdc_pkg.sv
hdl/bdc_cfg.sv
hdl/bdc_store.sv
hdl/bdc_step.sv
hdl/button_dimmer_channels_top.sv
test/button_dimmer_channels_top_tb.sv
